### rtl/gbic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO bank IRQ controller package
// Shared command codes, interrupt numbers and the job type that the front end
// hands to the emitter through the job queue.
// ----------------------------------------------------------------------------
package gbic_pkg;

	localparam logic [2:0] CMD_WR_DATA  = 3'd0;
	localparam logic [2:0] CMD_WR_DIR   = 3'd1;
	localparam logic [2:0] CMD_WR_TRIG  = 3'd2;
	localparam logic [2:0] CMD_WR_EN    = 3'd3;
	localparam logic [2:0] CMD_SET_LINE = 3'd4;

	localparam logic [6:0] IRQ_A_LINE0 = 7'h64;
	localparam logic [6:0] IRQ_A_LINE1 = 7'h66;
	localparam logic [6:0] IRQ_B_BASE  = 7'h68;

	// Bank B has twelve interrupt lines; bank A uses the low two of them.
	localparam int PEND_W = 12;
	localparam int SEL_W  = 4;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic              grp_b;
		logic [PEND_W-1:0] pend;
	} gbic_job_t;

endpackage
`default_nettype wire

### rtl/gbic_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO bank IRQ controller front end
// Holds the per-bank registers, applies one command per beat, re-evaluates the
// bank and queues the newly asserted interrupt lines as one job.
// ----------------------------------------------------------------------------
module gbic_front #(
	parameter int NUM_BANKS  = 4,
	parameter int IRQ_BANK_A = 1,
	parameter int IRQ_BANK_B = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [2:0]        command,
	input  wire logic [1:0]        bank,
	input  wire logic [15:0]       mask,
	input  wire logic [15:0]       value,
	input  wire logic [3:0]        line,
	input  wire logic              level,
	output logic                   push,
	output gbic_pkg::gbic_job_t    job
);
	import gbic_pkg::*;

	localparam int IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

	logic [15:0] data_q     [NUM_BANKS];
	logic [15:0] dir_q      [NUM_BANKS];
	logic [15:0] trig_q     [NUM_BANKS];
	logic [15:0] en_q       [NUM_BANKS];
	logic [15:0] asserted_q [NUM_BANKS];

	logic [IDX_W-1:0] idx;
	logic             in_range;
	logic             is_a;
	logic             is_b;
	logic             eval;
	logic [15:0]      line_bit;
	logic [15:0]      nd;
	logic [15:0]      ndir;
	logic [15:0]      nt;
	logic [15:0]      ne;
	logic [15:0]      now_lines;
	logic [15:0]      fresh;

	assign idx      = IDX_W'(bank);
	assign in_range = int'(bank) < NUM_BANKS;
	assign is_a     = int'(bank) == IRQ_BANK_A;
	assign is_b     = !is_a && (int'(bank) == IRQ_BANK_B);
	assign line_bit = 16'd1 << line;

	always_comb begin
		nd   = data_q[idx];
		ndir = dir_q[idx];
		nt   = trig_q[idx];
		ne   = en_q[idx];
		eval = 1'b0;
		case (command)
			CMD_WR_DATA: begin
				// Only lines configured as outputs take the new value.
				nd   = (data_q[idx] & ~(mask & dir_q[idx])) | (value & mask & dir_q[idx]);
				eval = 1'b1;
			end
			CMD_WR_DIR: begin
				ndir = (dir_q[idx] & ~mask) | (value & mask);
			end
			CMD_WR_TRIG: begin
				nt   = (trig_q[idx] & ~mask) | (value & mask);
				eval = 1'b1;
			end
			CMD_WR_EN: begin
				ne   = (en_q[idx] & ~mask) | (value & mask);
				eval = 1'b1;
			end
			CMD_SET_LINE: begin
				nd   = level ? (data_q[idx] | line_bit) : (data_q[idx] & ~line_bit);
				eval = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign now_lines = ~(nd ^ nt) & ne;
	assign fresh     = now_lines & ~asserted_q[idx];

	always_comb begin
		job.grp_b = is_b;
		if (is_a) begin
			job.pend = PEND_W'(fresh[1:0]);
		end else if (is_b) begin
			job.pend = fresh[PEND_W-1:0];
		end else begin
			job.pend = '0;
		end
	end

	assign push = accept && in_range && eval && (job.pend != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BANKS; i++) begin
				data_q[i]     <= '0;
				dir_q[i]      <= '0;
				trig_q[i]     <= '0;
				en_q[i]       <= '0;
				asserted_q[i] <= '0;
			end
		end else if (accept && in_range) begin
			data_q[idx] <= nd;
			dir_q[idx]  <= ndir;
			trig_q[idx] <= nt;
			en_q[idx]   <= ne;
			if (eval) begin
				asserted_q[idx] <= now_lines;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/gbic_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO bank IRQ controller job queue
// A short FIFO of interrupt jobs between the front end and the emitter.
// ----------------------------------------------------------------------------
module gbic_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire gbic_pkg::gbic_job_t push_job,
	input  wire logic              pop,
	output gbic_pkg::gbic_job_t    pop_job,
	output logic                   full,
	output logic                   empty
);
	import gbic_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	gbic_job_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/gbic_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO bank IRQ controller emitter
// Takes one job at a time and emits its pending lines in ascending order, one
// interrupt number per cycle, with the last beat of the job marked.
// ----------------------------------------------------------------------------
module gbic_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gbic_pkg::gbic_job_t job,
	input  wire logic              job_avail,
	output logic                   pop,
	output logic                   irq_strobe,
	output logic [6:0]             irq_number,
	output logic                   last
);
	import gbic_pkg::*;

	logic [PEND_W-1:0] pend_q;
	logic              grp_b_q;
	logic              active;
	logic [PEND_W-1:0] low_bit;
	logic [PEND_W-1:0] rest;
	logic [SEL_W-1:0]  sel;
	logic [6:0]        irq_next;
	logic              strobe_q;
	logic [6:0]        irq_q;
	logic              last_q;

	assign active  = pend_q != '0;
	assign low_bit = pend_q & (~pend_q + 1'b1);
	assign rest    = pend_q & ~low_bit;

	always_comb begin
		sel = '0;
		for (int j = 0; j < PEND_W; j++) begin
			if (low_bit[j]) begin
				sel = sel | SEL_W'(j);
			end
		end
	end

	always_comb begin
		if (grp_b_q) begin
			irq_next = IRQ_B_BASE + 7'(sel);
		end else if (sel == '0) begin
			irq_next = IRQ_A_LINE0;
		end else begin
			irq_next = IRQ_A_LINE1;
		end
	end

	// A new job is loaded in the same cycle as the final beat of the current one.
	assign pop = job_avail && (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			grp_b_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active;
			if (pop) begin
				pend_q  <= job.pend;
				grp_b_q <= job.grp_b;
			end else begin
				pend_q  <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		irq_q  <= irq_next;
		last_q <= rest == '0;
	end

	assign irq_strobe = strobe_q;
	assign irq_number = irq_q;
	assign last       = last_q;

endmodule
`default_nettype wire

### rtl/gpio_bank_irq_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO bank IRQ controller
// Banks of sixteen GPIO lines with masked register writes and level-match
// interrupts; newly asserted lines are reported as interrupt numbers.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// command   in         start && !busy       command, bank, mask, value, line, level
// result    out        irq_strobe (1 cycle) irq_number, last
//
// A command is applied to the bank registers in the cycle it is accepted.
// Its interrupts pass through the job queue and the emitter's pending and
// output registers, one per cycle; the emitter serializes the lines.
// busy rises when the two-entry job queue is full and clears as the emitter
// drains it. The receiver cannot stall. Reset clears all bank registers.
// ----------------------------------------------------------------------------
module gpio_bank_irq_controller #(
	parameter int NUM_BANKS  = 4,
	parameter int IRQ_BANK_A = 1,
	parameter int IRQ_BANK_B = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [1:0]  bank,
	input  wire logic [15:0] mask,
	input  wire logic [15:0] value,
	input  wire logic [3:0]  line,
	input  wire logic        level,
	output logic             irq_strobe,
	output logic [6:0]       irq_number,
	output logic             last
);
	import gbic_pkg::*;

	logic      accept;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;
	gbic_job_t push_job;
	gbic_job_t pop_job;

	assign busy   = q_full;
	assign accept = start && !busy;

	gbic_front #(
		.NUM_BANKS  (NUM_BANKS),
		.IRQ_BANK_A (IRQ_BANK_A),
		.IRQ_BANK_B (IRQ_BANK_B)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.command (command),
		.bank    (bank),
		.mask    (mask),
		.value   (value),
		.line    (line),
		.level   (level),
		.push    (push),
		.job     (push_job)
	);

	gbic_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	gbic_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (pop_job),
		.job_avail  (!q_empty),
		.pop        (pop),
		.irq_strobe (irq_strobe),
		.irq_number (irq_number),
		.last       (last)
	);

`ifndef SYNTHESIS
	// Every emitted number lies in the interrupt range of the two groups.
	a_irq_range: assert property (@(posedge clk) disable iff (!arst_n)
		irq_strobe |-> (irq_number >= 7'd100) && (irq_number <= 7'd115))
		else $error("interrupt number out of range");

	// The beats of one command are contiguous until the last one.
	a_job_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		irq_strobe && !last |=> irq_strobe)
		else $error("gap inside an interrupt burst");

	// The front end never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job queue overflow");
`endif

endmodule
`default_nettype wire

### sim/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO bank IRQ controller testbench
// Sends bank commands through the start/busy handshake, predicts the interrupt
// numbers of every newly asserted line from a private copy of the bank
// registers, and checks each strobed interrupt beat against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import gbic_pkg::*;

	localparam int NUM_BANKS  = 4;
	localparam int IRQ_BANK_A = 1;
	localparam int IRQ_BANK_B = 3;

	// Command codes that the block does not decode.
	localparam logic [2:0] CMD_RSVD_5 = 3'd5;
	localparam logic [2:0] CMD_RSVD_6 = 3'd6;
	localparam logic [2:0] CMD_RSVD_7 = 3'd7;

	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic [6:0] irq_number;
		logic       last;
	} irq_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  command = CMD_WR_DATA;
	logic [1:0]  bank = 2'd0;
	logic [15:0] mask = 16'h0000;
	logic [15:0] value = 16'h0000;
	logic [3:0]  line = 4'd0;
	logic        level = 1'b0;
	logic        irq_strobe;
	logic [6:0]  irq_number;
	logic        last;

	// Private copy of the bank registers.
	logic [15:0] bank_data     [NUM_BANKS];
	logic [15:0] bank_dir      [NUM_BANKS];
	logic [15:0] bank_trig     [NUM_BANKS];
	logic [15:0] bank_en       [NUM_BANKS];
	logic [15:0] bank_asserted [NUM_BANKS];

	irq_beat_t expected_irqs[$];

	int sender_idle_pct = 0;
	int cmds_sent = 0;
	int cmds_ignored = 0;
	int irqs_checked = 0;
	int longest_burst = 0;
	int error_count = 0;
	int stall_cycles = 0;

	gpio_bank_irq_controller #(
		.NUM_BANKS  (NUM_BANKS),
		.IRQ_BANK_A (IRQ_BANK_A),
		.IRQ_BANK_B (IRQ_BANK_B)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.bank       (bank),
		.mask       (mask),
		.value      (value),
		.line       (line),
		.level      (level),
		.irq_strobe (irq_strobe),
		.irq_number (irq_number),
		.last       (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Applies one accepted command to the register copy and queues the interrupt
	// beats of the lines that it newly asserts.
	task automatic predict_irqs(input logic [2:0] cmd, input logic [1:0] bk,
			input logic [15:0] msk, input logic [15:0] val, input logic [3:0] ln,
			input logic lvl);
		logic [15:0] out_mask;
		logic [15:0] now_lines;
		logic [15:0] fresh;
		irq_beat_t   burst[$];
		irq_beat_t   beat;
		if (int'(bk) >= NUM_BANKS)
			return;
		case (cmd)
			CMD_WR_DATA: begin
				out_mask = msk & bank_dir[bk];
				bank_data[bk] = (bank_data[bk] & ~out_mask) | (val & out_mask);
			end
			CMD_WR_DIR: begin
				bank_dir[bk] = (bank_dir[bk] & ~msk) | (val & msk);
				return;
			end
			CMD_WR_TRIG: bank_trig[bk] = (bank_trig[bk] & ~msk) | (val & msk);
			CMD_WR_EN: bank_en[bk] = (bank_en[bk] & ~msk) | (val & msk);
			CMD_SET_LINE: bank_data[bk][ln] = lvl;
			default: return;
		endcase
		now_lines = ~(bank_data[bk] ^ bank_trig[bk]) & bank_en[bk];
		fresh = now_lines & ~bank_asserted[bk];
		bank_asserted[bk] = now_lines;
		beat.last = 1'b0;
		if (int'(bk) == IRQ_BANK_A) begin
			if (fresh[0]) begin
				beat.irq_number = IRQ_A_LINE0;
				burst.push_back(beat);
			end
			if (fresh[1]) begin
				beat.irq_number = IRQ_A_LINE1;
				burst.push_back(beat);
			end
		end else if (int'(bk) == IRQ_BANK_B) begin
			for (int j = 0; j < PEND_W; j++) begin
				if (fresh[j]) begin
					beat.irq_number = IRQ_B_BASE + 7'(j);
					burst.push_back(beat);
				end
			end
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		if (burst.size() > longest_burst)
			longest_burst = burst.size();
		foreach (burst[i])
			expected_irqs.push_back(burst[i]);
	endtask

	// Holds one command on the ports until it is accepted, then maybe idles.
	task automatic send_cmd(input logic [2:0] cmd, input logic [1:0] bk,
			input logic [15:0] msk, input logic [15:0] val, input logic [3:0] ln,
			input logic lvl);
		start   <= 1'b1;
		command <= cmd;
		bank    <= bk;
		mask    <= msk;
		value   <= val;
		line    <= ln;
		level   <= lvl;
		do @(posedge clk); while (busy);
		cmds_sent++;
		if (cmd > CMD_SET_LINE)
			cmds_ignored++;
		predict_irqs(cmd, bk, msk, val, ln, lvl);
		if ($urandom_range(99) < sender_idle_pct) begin
			// Junk on the payload ports while start is low must be ignored.
			start   <= 1'b0;
			command <= 3'($urandom);
			bank    <= 2'($urandom);
			mask    <= 16'($urandom);
			value   <= 16'($urandom);
			line    <= 4'($urandom);
			level   <= 1'($urandom);
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_all_irqs();
		if (start)
			start <= 1'b0;
		while (expected_irqs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Every check of an interrupt beat happens here.
	always @(posedge clk) begin
		irq_beat_t exp_beat;
		if (arst_n && irq_strobe) begin
			if (expected_irqs.size() == 0) begin
				$error("unexpected interrupt beat: irq_number=0x%0h last=%0b",
					irq_number, last);
				error_count++;
			end else begin
				exp_beat = expected_irqs.pop_front();
				irqs_checked++;
				if (irq_number !== exp_beat.irq_number) begin
					$error("irq_number: expected 0x%0h, actual 0x%0h",
						exp_beat.irq_number, irq_number);
					error_count++;
				end
				if (last !== exp_beat.last) begin
					$error("last: expected %0b, actual %0b", exp_beat.last, last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || irq_strobe)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	// Enabling every line of bank B at once gives the longest burst; the lines
	// above the twelfth join the asserted set but never raise an interrupt.
	task automatic test_bank_b_burst();
		send_cmd(CMD_WR_DIR, 2'(IRQ_BANK_B), 16'hFFFF, 16'h00FF, 4'd0, 1'b0);
		send_cmd(CMD_WR_EN, 2'(IRQ_BANK_B), 16'hFFFF, 16'hFFFF, 4'd0, 1'b0);
		send_cmd(CMD_WR_DATA, 2'(IRQ_BANK_B), 16'hFFFF, 16'hFFFF, 4'd0, 1'b0);
		send_cmd(CMD_SET_LINE, 2'(IRQ_BANK_B), 16'h0000, 16'h0000, 4'd15, 1'b1);
		send_cmd(CMD_SET_LINE, 2'(IRQ_BANK_B), 16'h0000, 16'h0000, 4'd3, 1'b0);
		send_cmd(CMD_WR_TRIG, 2'(IRQ_BANK_B), 16'hFFFF, 16'hFFFF, 4'd0, 1'b0);
	endtask

	task automatic test_bank_a_lines();
		send_cmd(CMD_WR_EN, 2'(IRQ_BANK_A), 16'hFFFF, 16'h0003, 4'd0, 1'b0);
		send_cmd(CMD_SET_LINE, 2'(IRQ_BANK_A), 16'h0000, 16'h0000, 4'd0, 1'b1);
		send_cmd(CMD_WR_TRIG, 2'(IRQ_BANK_A), 16'h0001, 16'h0001, 4'd0, 1'b0);
		send_cmd(CMD_SET_LINE, 2'(IRQ_BANK_A), 16'h0000, 16'h0000, 4'd1, 1'b1);
	endtask

	task automatic test_quiet_banks();
		send_cmd(CMD_WR_EN, 2'd0, 16'hFFFF, 16'hFFFF, 4'd0, 1'b0);
		send_cmd(CMD_WR_EN, 2'd2, 16'hFFFF, 16'hFFFF, 4'd0, 1'b0);
		send_cmd(CMD_SET_LINE, 2'd0, 16'h0000, 16'h0000, 4'd5, 1'b1);
	endtask

	task automatic test_ignored_commands();
		send_cmd(CMD_RSVD_5, 2'(IRQ_BANK_B), 16'hFFFF, 16'h0000, 4'd0, 1'b0);
		send_cmd(CMD_RSVD_6, 2'(IRQ_BANK_A), 16'hFFFF, 16'hFFFF, 4'd1, 1'b1);
		send_cmd(CMD_RSVD_7, 2'(IRQ_BANK_B), 16'h0000, 16'hFFFF, 4'd15, 1'b1);
	endtask

	task automatic test_field_extremes();
		send_cmd(CMD_WR_DATA, 2'(IRQ_BANK_A), 16'h0000, 16'hFFFF, 4'd15, 1'b1);
		send_cmd(CMD_WR_TRIG, 2'(IRQ_BANK_B), 16'hFFFF, 16'h0000, 4'd0, 1'b0);
		send_cmd(CMD_SET_LINE, 2'(IRQ_BANK_B), 16'hFFFF, 16'hFFFF, 4'd0, 1'b0);
		send_cmd(CMD_SET_LINE, 2'(IRQ_BANK_A), 16'h0000, 16'h0000, 4'd15, 1'b1);
	endtask

	task automatic test_drain_pause();
		wait_all_irqs();
		send_cmd(CMD_SET_LINE, 2'(IRQ_BANK_B), 16'h0000, 16'h0000, 4'd0, 1'b1);
	endtask

	// Most traffic goes to the two interrupt banks and toggles lines, which
	// keeps fresh assertions coming; reserved codes are rare noise.
	task automatic test_random_traffic(input int idle_pct, input int n_items);
		logic [2:0]  cmd;
		logic [1:0]  bk;
		logic [15:0] msk;
		int          sent;
		int          pick;
		sender_idle_pct = idle_pct;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 4)
				cmd = CMD_RSVD_5 + 3'($urandom_range(2));
			else if (pick < 40)
				cmd = CMD_SET_LINE;
			else if (pick < 60)
				cmd = CMD_WR_DATA;
			else if (pick < 75)
				cmd = CMD_WR_TRIG;
			else if (pick < 88)
				cmd = CMD_WR_EN;
			else
				cmd = CMD_WR_DIR;
			pick = $urandom_range(9);
			if (pick < 4)
				bk = 2'(IRQ_BANK_B);
			else if (pick < 7)
				bk = 2'(IRQ_BANK_A);
			else
				bk = (pick == 7) ? 2'd0 : 2'd2;
			pick = $urandom_range(7);
			if (pick == 0)
				msk = 16'hFFFF;
			else if (pick == 1)
				msk = 16'h0000;
			else
				msk = 16'($urandom);
			send_cmd(cmd, bk, msk, 16'($urandom), 4'($urandom), 1'($urandom));
			if (cmd <= CMD_SET_LINE)
				sent++;
		end
	endtask

	initial begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			bank_data[b] = '0;
			bank_dir[b] = '0;
			bank_trig[b] = '0;
			bank_en[b] = '0;
			bank_asserted[b] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bank_b_burst();
		test_bank_a_lines();
		test_quiet_banks();
		test_ignored_commands();
		test_field_extremes();
		test_random_traffic(13, 117);
		test_drain_pause();
		test_random_traffic(83, 117);
		test_random_traffic(0, 116);
		wait_all_irqs();
		if (expected_irqs.size() != 0) begin
			$error("%0d interrupt beats never arrived", expected_irqs.size());
			error_count++;
		end
		$display("Run covered %0d commands (%0d reserved codes) on all banks.",
			cmds_sent, cmds_ignored);
		$display("Checked %0d interrupt beats; longest burst was %0d beats.",
			irqs_checked, longest_burst);
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
